>>> rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold in the same cycle as its trigger
`define ELF_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define ELF_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> rtl/elf_pkg.sv
// shared constants, codes and types of the eased led fill animator
package elf_pkg;

  // fixed point of the easing curve
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int PROD_W    = 2 * T_W;
  localparam logic [T_W-1:0] ONE  = T_W'(1) << FRAC_BITS;
  localparam logic [T_W-1:0] HALF = T_W'(1) << (FRAC_BITS - 1);
  localparam int CNT_W     = $clog2(FRAC_BITS) + 1;

  // field widths
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int LEN_W   = 11;
  localparam int PIX_W   = 16;
  localparam int COLOR_W = 24;
  localparam int MAX_LEDS = 1024;

  // input beat layout
  localparam int IN_TIME_LSB = 0;
  localparam int IN_TGT_BIT  = TIME_W;
  localparam int IN_PIX_LSB  = TIME_W + 1;
  localparam int IN_USED_W   = IN_PIX_LSB + PIX_W;
  localparam int IN_W        = ((IN_USED_W + 7) / 8) * 8;

  // output beat layout
  localparam int OUT_CHG_BIT   = LEN_W;
  localparam int OUT_ACT_BIT   = LEN_W + 1;
  localparam int OUT_COLOR_LSB = LEN_W + 2;
  localparam int OUT_USED_W    = OUT_COLOR_LSB + COLOR_W;
  localparam int OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_START = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR     = 2'd3;

  // register reset values
  localparam logic [DUR_W-1:0]   DUR_RST   = 16'd500;
  localparam logic [LEN_W-1:0]   LEN_RST   = 11'd1024;
  localparam logic [PIX_W-1:0]   START_RST = 16'd0;
  localparam logic [COLOR_W-1:0] COLOR_RST = 24'hFFFFFF;
  localparam logic [COLOR_W-1:0] BLACK     = 24'h000000;

  // command codes
  localparam logic CMD_TICK  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // status of an iterative unit
  typedef struct packed {
    logic busy;
    logic done;
  } elf_stat_t;

endpackage

>>> rtl/eased_led_fill_animator.sv
// top level: config registers, tick and query sequencer, result register
// a tick that moves the clock goes from the accepting edge to out_tvalid through the steps
// (update, divider start, 16 divider steps, multiplier start, 4 phases, count write, result)
// without the divider steps when the ratio saturates at one; a tick that leaves the clock alone
// takes update and result, a query only the result; one item at a time, out_tready stalls hold it
// rst_n (synchronous) clears the animation state and loads the register defaults
module eased_led_fill_animator import elf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // slave side
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,   // time_ms, target_on, pixel_index, zero pad
  input  logic                 in_tuser,   // cmd
  // master side
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,  // lit_count, count_changed, active, pixel_color, pad
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIVS = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_EASE = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0]         state_r;
  logic [2:0]         state_nxt;
  logic [DUR_W-1:0]   dur_r;
  logic [LEN_W-1:0]   len_r;
  logic [PIX_W-1:0]   start_r;
  logic [COLOR_W-1:0] color_cfg_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [DUR_W-1:0]   anim_r;
  logic [DUR_W-1:0]   anim_nxt;
  logic               upd;
  logic [LEN_W-1:0]   lit_pos_r;
  logic [TIME_W-1:0]  delta_r;
  logic               tgt_r;
  logic               changed_r;
  logic [COLOR_W-1:0] color_r;
  logic               out_valid_r;
  logic [OUT_W-1:0]   out_data_r;
  logic               in_beat;
  logic               out_free;
  logic [TIME_W-1:0]  in_time;
  logic [PIX_W-1:0]   in_pix;
  logic [PIX_W-1:0]   local_idx;
  logic [DUR_W-1:0]   dur_eff;
  logic [LEN_W-1:0]   len_eff;
  logic [TIME_W:0]    up_sum;
  elf_stat_t          div_stat;
  elf_stat_t          ease_stat;
  logic [T_W-1:0]     ratio;
  logic [LEN_W-1:0]   lit_new;

  assign in_time   = in_tdata[IN_TIME_LSB +: TIME_W];
  assign in_pix    = in_tdata[IN_PIX_LSB +: PIX_W];
  assign in_tready = state_r == S_IDLE;
  assign in_beat   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;

  assign dur_eff   = (dur_r == '0) ? DUR_W'(1) : dur_r;
  assign len_eff   = (len_r > LEN_W'(MAX_LEDS)) ? LEN_W'(MAX_LEDS) : len_r;
  assign local_idx = in_pix - start_r;

  // animation clock step
  always_comb begin
    up_sum   = {{(TIME_W + 1 - DUR_W){1'b0}}, anim_r} + {1'b0, delta_r};
    anim_nxt = anim_r;
    upd      = 1'b0;
    if (tgt_r) begin
      if (anim_r != dur_eff) begin
        anim_nxt = (up_sum > {{(TIME_W + 1 - DUR_W){1'b0}}, dur_eff}) ? dur_eff
                                                                     : up_sum[DUR_W-1:0];
        upd      = 1'b1;
      end
    end else if (anim_r != '0) begin
      anim_nxt = ({{(TIME_W - DUR_W){1'b0}}, anim_r} > delta_r)
               ? anim_r - delta_r[DUR_W-1:0] : '0;
      upd      = 1'b1;
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_beat) state_nxt = (in_tuser == CMD_QUERY) ? S_OUT : S_UPD;
      S_UPD:  state_nxt = upd ? S_DIVS : S_OUT;
      S_DIVS: state_nxt = S_DIV;
      S_DIV:  if (div_stat.done) state_nxt = S_EASE;
      S_EASE: if (ease_stat.done) state_nxt = S_OUT;
      S_OUT:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // ratio of clock to duration
  elf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (state_r == S_DIVS),
    .num   (anim_r),
    .den   (dur_eff),
    .stat  (div_stat),
    .quot  (ratio)
  );

  // eased lit count
  elf_ease u_ease (
    .clk   (clk),
    .rst_n (rst_n),
    .start ((state_r == S_DIV) && div_stat.done),
    .t     (ratio),
    .len   (len_eff),
    .stat  (ease_stat),
    .lit   (lit_new)
  );

  // control, state and configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dur_r       <= DUR_RST;
      len_r       <= LEN_RST;
      start_r     <= START_RST;
      color_cfg_r <= COLOR_RST;
      last_time_r <= '0;
      anim_r      <= '0;
      lit_pos_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DURATION:  dur_r       <= cfg_data[DUR_W-1:0];
          REG_SEG_LEN:   len_r       <= cfg_data[LEN_W-1:0];
          REG_SEG_START: start_r     <= cfg_data[PIX_W-1:0];
          REG_COLOR:     color_cfg_r <= cfg_data;
          default:       dur_r       <= dur_r;
        endcase
      end
      if (in_beat && (in_tuser == CMD_TICK)) last_time_r <= in_time;
      if (state_r == S_UPD) anim_r <= anim_nxt;
      if ((state_r == S_EASE) && ease_stat.done) lit_pos_r <= lit_new;
      // result register
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (in_beat) begin
      delta_r   <= in_time - last_time_r;
      tgt_r     <= in_tdata[IN_TGT_BIT];
      changed_r <= 1'b0;
      color_r   <= ((in_tuser == CMD_QUERY) && (local_idx < PIX_W'(lit_pos_r)))
                 ? color_cfg_r : BLACK;
    end else if ((state_r == S_EASE) && ease_stat.done) begin
      changed_r <= lit_new != lit_pos_r;
    end
    if (state_r == S_OUT && out_free) begin
      out_data_r <= {{(OUT_W - OUT_USED_W){1'b0}}, color_r, anim_r != '0, changed_r,
                     lit_pos_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/elf_div.sv
// restoring divider giving the saturated ratio (num << FRAC_BITS) / den
module elf_div import elf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DUR_W-1:0] num,
  input  logic [DUR_W-1:0] den,
  output elf_stat_t        stat,
  output logic [T_W-1:0]   quot
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DUR_W-1:0] rem_r;
  logic [DUR_W-1:0] den_r;
  logic [T_W-1:0]   q_r;
  logic [DUR_W:0]   shl;
  logic             ge;

  // one quotient bit per cycle
  assign shl = {rem_r, 1'b0};
  assign ge  = shl >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (num >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(FRAC_BITS);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      den_r <= den;
      rem_r <= num;
      q_r   <= (num >= den) ? ONE : '0;
    end else if (busy_r) begin
      rem_r <= ge ? DUR_W'(shl - {1'b0, den_r}) : shl[DUR_W-1:0];
      q_r   <= {q_r[T_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

>>> rtl/elf_ease.sv
// ease-in-out-cubic and length scaling over one shared multiplier
module elf_ease import elf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [T_W-1:0]   t,
  input  logic [LEN_W-1:0] len,
  output elf_stat_t        stat,
  output logic [LEN_W-1:0] lit
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_SQ   = 3'd1;
  localparam logic [2:0] PH_CUBE = 3'd2;
  localparam logic [2:0] PH_EASE = 3'd3;
  localparam logic [2:0] PH_LEN  = 3'd4;

  logic [2:0]        ph_r;
  logic              done_r;
  logic              lo_r;
  logic [T_W-1:0]    x_r;
  logic [T_W-1:0]    a_r;
  logic [T_W-1:0]    b_r;
  logic [LEN_W-1:0]  len_r;
  logic [LEN_W-1:0]  lit_r;
  logic [T_W:0]      u_full;
  logic [T_W-1:0]    x_in;
  logic [PROD_W-1:0] prod;
  logic [T_W-1:0]    prod_hi;
  logic [T_W-1:0]    e_val;

  // mirrored operand for the upper half of the curve
  assign u_full = {ONE, 1'b0} - {t, 1'b0};
  assign x_in   = (t < HALF) ? t : u_full[T_W-1:0];

  // the shared multiplier
  assign prod    = {{T_W{1'b0}}, a_r} * {{T_W{1'b0}}, b_r};
  assign prod_hi = prod[FRAC_BITS +: T_W];

  // eased value from the cube
  assign e_val = lo_r ? {a_r[T_W-3:0], 2'b00} : ONE - (a_r >> 1);

  // phase sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (ph_r)
        PH_IDLE: if (start) ph_r <= PH_SQ;
        PH_SQ:   ph_r <= PH_CUBE;
        PH_CUBE: ph_r <= PH_EASE;
        PH_EASE: ph_r <= PH_LEN;
        PH_LEN: begin
          ph_r   <= PH_IDLE;
          done_r <= 1'b1;
        end
        default: ph_r <= PH_IDLE;
      endcase
    end
  end

  // operands and results
  always_ff @(posedge clk) begin
    unique case (ph_r)
      PH_IDLE: begin
        if (start) begin
          lo_r  <= t < HALF;
          x_r   <= x_in;
          a_r   <= x_in;
          b_r   <= x_in;
          len_r <= len;
        end
      end
      PH_SQ: begin
        a_r <= prod_hi;
        b_r <= x_r;
      end
      PH_CUBE: a_r <= prod_hi;
      PH_EASE: begin
        a_r <= e_val;
        b_r <= T_W'(len_r);
      end
      PH_LEN:  lit_r <= prod[FRAC_BITS +: LEN_W];
      default: lit_r <= lit_r;
    endcase
  end

  assign stat.busy = ph_r != PH_IDLE;
  assign stat.done = done_r;
  assign lit       = lit_r;

endmodule

>>> rtl/elf_checker.sv
// port-level checker for the eased led fill animator, bound to the top level
`include "assert_macros.svh"

module elf_checker import elf_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [IN_W-1:0]      in_tdata,
  input logic                 in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [OUT_W-1:0]     out_tdata,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [COLOR_W-1:0]   cfg_data
);

  // a stalled result beat holds
  `ELF_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result beat changed while stalled")

  // one item at a time: no new beat right after one is taken
  `ELF_ASSERT_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken while an item is in work")

  // a changed count comes only from a tick, which answers black
  `ELF_ASSERT_NOW(a_chg_black, out_tvalid && out_tdata[OUT_CHG_BIT], out_tdata[OUT_COLOR_LSB +: COLOR_W] == BLACK, "changed flag on a colored result")

  // the lit count never exceeds the led limit
  `ELF_ASSERT_NOW(a_lit_max, out_tvalid, out_tdata[LEN_W-1:0] <= LEN_W'(MAX_LEDS), "lit count above limit")

endmodule

bind eased_led_fill_animator elf_checker u_elf_checker (.*);
